/* design/lcbm_pkg.sv */
package lcbm_pkg;

    localparam int SLOTS = 16;
    localparam int SLOT_W = 4;
    localparam int LOCK_BITS = 8;
    localparam int MAX_ENTRY_BYTES = 4096;
    localparam int SIZE_W = 13;
    localparam int BYTES_W = 24;
    localparam int CNT_W = 5;
    localparam logic [BYTES_W-1:0] UNKNOWN_PURGE_BYTES = BYTES_W'(1024 * 1024);

    typedef enum logic [2:0] {
        ACT_NEW     = 3'd0,
        ACT_LOCK    = 3'd1,
        ACT_UNLOCK  = 3'd2,
        ACT_RELEASE = 3'd3,
        ACT_PURGE   = 3'd4,
        ACT_QUERY   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_GONE    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } fsm_t;

    typedef struct packed {
        action_t                 action;
        logic [SLOT_W-1:0]       slot;
        logic [SIZE_W-1:0]       entry_size;
        logic [BYTES_W-1:0]      purge_amount;
        logic                    amount_unknown;
        logic                    own_pool;
    } req_t;

    typedef struct packed {
        status_t                 status;
        logic                    present;
        logic [BYTES_W-1:0]      purged_bytes;
        logic [SLOTS-1:0]        evicted_mask;
        logic [BYTES_W-1:0]      cache_bytes;
        logic [CNT_W-1:0]        valid_count;
        logic [CNT_W-1:0]        object_count;
    } rsp_t;

    // Commands to the recency chain.
    typedef enum logic [1:0] {
        ORD_NONE,
        ORD_HEAD,    // remove slot (if held), insert at head
        ORD_REMOVE,  // remove slot if held
        ORD_SHIFT    // no action in the cells; contents hold
    } ord_op_t;

    typedef struct packed {
        ord_op_t             op;
        logic [SLOT_W-1:0]   slot;
    } ord_cmd_t;

endpackage

/* design/lcbm_if.sv */
interface lcbm_req_if;
    lcbm_pkg::req_t payload;
    logic valid;
    logic ready;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lcbm_rsp_if;
    lcbm_pkg::rsp_t payload;
    logic valid;
    logic ready;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lcbm_cfg_if;
    logic [23:0] data;
    logic valid;
    logic ready;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/lcbm_cell.sv */
// One position of the recency order. Position 0 is most recent.
module lcbm_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lcbm_pkg::ord_cmd_t            cmd,
    input  logic                          left_valid,
    input  logic [lcbm_pkg::SLOT_W-1:0]   left_slot,
    input  logic                          left_hit_seen,
    input  logic                          right_valid,
    input  logic [lcbm_pkg::SLOT_W-1:0]   right_slot,
    input  logic                          right_hit,
    input  logic                          is_head,
    output logic                          valid,
    output logic [lcbm_pkg::SLOT_W-1:0]   slot,
    output logic                          hit,
    output logic                          hit_seen
);
    logic                        valid_reg, valid_next;
    logic [lcbm_pkg::SLOT_W-1:0] slot_reg, slot_next;

    assign valid = valid_reg;
    assign slot = slot_reg;
    assign hit = valid_reg && (slot_reg == cmd.slot);
    // hit at or above this position (toward head)
    assign hit_seen = left_hit_seen || hit;

    // Next contents
    always_comb
    begin
        valid_next = valid_reg;
        slot_next = slot_reg;
        case (cmd.op)
            lcbm_pkg::ORD_HEAD:
            begin
                if (is_head)
                begin
                    valid_next = 1'b1;
                    slot_next = cmd.slot;
                end
                else if (!left_hit_seen)
                begin
                    valid_next = left_valid;
                    slot_next = left_slot;
                end
            end
            lcbm_pkg::ORD_REMOVE:
            begin
                if (hit_seen)
                begin
                    valid_next = right_valid && !right_hit;
                    slot_next = right_slot;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            slot_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            slot_reg <= slot_next;
        end
    end
endmodule

/* design/lcbm_chain.sv */
// Row of order cells; the tail is the highest valid position.
module lcbm_chain
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  lcbm_pkg::ord_cmd_t                            cmd,
    output logic [lcbm_pkg::SLOTS-1:0]                    pos_valid,
    output logic [lcbm_pkg::SLOTS-1:0][lcbm_pkg::SLOT_W-1:0] pos_slot
);
    logic [lcbm_pkg::SLOTS-1:0] hit;
    logic [lcbm_pkg::SLOTS-1:0] hit_seen;

    for (genvar i = 0; i < lcbm_pkg::SLOTS; i++)
    begin : g_cell
        logic                        lv, ls_seen, rv, rh;
        logic [lcbm_pkg::SLOT_W-1:0] ls, rs;
        if (i == 0)
        begin : g_first
            assign lv = 1'b0;
            assign ls = '0;
            assign ls_seen = 1'b0;
        end
        else
        begin : g_mid
            assign lv = pos_valid[i-1];
            assign ls = pos_slot[i-1];
            assign ls_seen = hit_seen[i-1];
        end
        if (i == lcbm_pkg::SLOTS - 1)
        begin : g_last
            assign rv = 1'b0;
            assign rs = '0;
            assign rh = 1'b0;
        end
        else
        begin : g_inner
            assign rv = pos_valid[i+1];
            assign rs = pos_slot[i+1];
            assign rh = hit[i+1];
        end
        lcbm_cell u_cell
        (
            .clk           (clk),
            .rst_n         (rst_n),
            .cmd           (cmd),
            .left_valid    (lv),
            .left_slot     (ls),
            .left_hit_seen (ls_seen),
            .right_valid   (rv),
            .right_slot    (rs),
            .right_hit     (rh),
            .is_head       (i == 0),
            .valid         (pos_valid[i]),
            .slot          (pos_slot[i]),
            .hit           (hit[i]),
            .hit_seen      (hit_seen[i])
        );
    end
endmodule

/* design/lru_cache_budget_manager.sv */
// Channel   Dir  Payload
// req       in   action, slot, entry_size, purge_amount, amount_unknown, own_pool
// rsp       out  status, present, purged_bytes, evicted_mask, cache_bytes, counts
// cfg       in   max_cache_bytes (24 bits)
// One request at a time; each result is held in the response register. A purge
// walk scans up to 16 order positions, one position per cycle from the last
// cell of the chain toward the head.
// rst_n clears all flags, counts, the order and the budget.
// A waiting response holds the block; req.ready is low until it is taken.
module lru_cache_budget_manager
(
    input  logic               clk,
    input  logic               rst_n,
    lcbm_req_if.sink           req,
    lcbm_rsp_if.source         rsp,
    lcbm_cfg_if.sink           cfg
);
    localparam int S = lcbm_pkg::SLOTS;
    localparam int SW = lcbm_pkg::SLOT_W;
    localparam int BW = lcbm_pkg::BYTES_W;
    localparam int CW = lcbm_pkg::CNT_W;

    lcbm_pkg::fsm_t state_reg, state_next;
    lcbm_pkg::req_t req_reg;
    logic [BW-1:0]  budget_reg;

    logic [S-1:0]                       alloc_reg, alloc_next;
    logic [S-1:0]                       pres_reg, pres_next;
    logic [S-1:0][lcbm_pkg::LOCK_BITS-1:0] lock_reg, lock_next;
    logic [S-1:0][lcbm_pkg::SIZE_W-1:0] size_reg;
    logic [BW-1:0] total_reg, total_next;
    logic [CW-1:0] acnt_reg, acnt_next, pcnt_reg, pcnt_next;

    logic [BW-1:0]  target_reg, target_next;
    logic [BW-1:0]  freed_reg, freed_next;
    logic [S-1:0]   mask_reg, mask_next;
    logic [CW-1:0]  pos_reg, pos_next;
    lcbm_pkg::status_t status_reg, status_next;

    lcbm_pkg::rsp_t rsp_reg;
    logic           rsp_valid_reg;

    lcbm_pkg::ord_cmd_t cmd;
    logic [S-1:0]          pos_valid;
    logic [S-1:0][SW-1:0]  pos_slot;

    lcbm_chain u_chain
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .pos_valid (pos_valid),
        .pos_slot  (pos_slot)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == lcbm_pkg::S_IDLE) && !rsp_valid_reg;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.payload = rsp_reg;

    logic [SW-1:0]  s;
    logic [lcbm_pkg::SIZE_W-1:0] csize;
    logic           walk_start;
    logic [BW-1:0]  new_total;
    logic           lmax;

    assign s = req_reg.slot;
    assign csize = (req_reg.entry_size > lcbm_pkg::SIZE_W'(lcbm_pkg::MAX_ENTRY_BYTES))
        ? lcbm_pkg::SIZE_W'(lcbm_pkg::MAX_ENTRY_BYTES) : req_reg.entry_size;
    assign new_total = total_reg + BW'(csize);
    assign lmax = &lock_reg[s];

    // Request execution and purge walk
    always_comb
    begin
        state_next = state_reg;
        alloc_next = alloc_reg;
        pres_next = pres_reg;
        lock_next = lock_reg;
        total_next = total_reg;
        acnt_next = acnt_reg;
        pcnt_next = pcnt_reg;
        target_next = target_reg;
        freed_next = freed_reg;
        mask_next = mask_reg;
        pos_next = pos_reg;
        status_next = status_reg;
        cmd.op = lcbm_pkg::ORD_NONE;
        cmd.slot = s;
        walk_start = 1'b0;
        unique case (state_reg)
            lcbm_pkg::S_IDLE:
            begin
                if (req.valid && req.ready)
                    state_next = lcbm_pkg::S_WALK;
                freed_next = '0;
                mask_next = '0;
                status_next = lcbm_pkg::ST_OK;
            end
            lcbm_pkg::S_WALK:
            begin
                // execute the request; a walk start loads pos_next with the chain length S
                state_next = lcbm_pkg::S_DONE;
                case (req_reg.action)
                    lcbm_pkg::ACT_NEW:
                    begin
                        if (alloc_reg[s])
                            status_next = lcbm_pkg::ST_INVALID;
                        else
                        begin
                            alloc_next[s] = 1'b1;
                            pres_next[s] = 1'b1;
                            lock_next[s] = '0;
                            acnt_next = acnt_reg + 1'b1;
                            pcnt_next = pcnt_reg + 1'b1;
                            total_next = new_total;
                            cmd.op = lcbm_pkg::ORD_HEAD;
                            if (budget_reg != '0 && new_total > budget_reg)
                            begin
                                walk_start = 1'b1;
                                target_next = new_total - budget_reg;
                            end
                        end
                    end
                    lcbm_pkg::ACT_LOCK:
                    begin
                        if (!alloc_reg[s])
                            status_next = lcbm_pkg::ST_INVALID;
                        else if (!pres_reg[s])
                            status_next = lcbm_pkg::ST_GONE;
                        else if (!lmax)
                            lock_next[s] = lock_reg[s] + 1'b1;
                    end
                    lcbm_pkg::ACT_UNLOCK:
                    begin
                        if (!alloc_reg[s] || lock_reg[s] == '0)
                            status_next = lcbm_pkg::ST_INVALID;
                        else
                        begin
                            lock_next[s] = lock_reg[s] - 1'b1;
                            if (lock_reg[s] == lcbm_pkg::LOCK_BITS'(1) && pres_reg[s])
                                cmd.op = lcbm_pkg::ORD_HEAD;
                        end
                    end
                    lcbm_pkg::ACT_RELEASE:
                    begin
                        if (!alloc_reg[s])
                            status_next = lcbm_pkg::ST_INVALID;
                        else
                        begin
                            if (pres_reg[s])
                            begin
                                cmd.op = lcbm_pkg::ORD_REMOVE;
                                total_next = total_reg - BW'(size_reg[s]);
                                pcnt_next = pcnt_reg - 1'b1;
                                pres_next[s] = 1'b0;
                            end
                            alloc_next[s] = 1'b0;
                            lock_next[s] = '0;
                            acnt_next = acnt_reg - 1'b1;
                        end
                    end
                    lcbm_pkg::ACT_PURGE:
                    begin
                        if (!req_reg.own_pool)
                        begin
                            walk_start = 1'b1;
                            target_next = req_reg.amount_unknown
                                ? lcbm_pkg::UNKNOWN_PURGE_BYTES : req_reg.purge_amount;
                        end
                    end
                    lcbm_pkg::ACT_QUERY:
                    begin
                    end
                    default: status_next = lcbm_pkg::ST_INVALID;
                endcase
                if (req_reg.action == lcbm_pkg::ACT_QUERY)
                    status_next = lcbm_pkg::ST_OK;
                if (walk_start)
                begin
                    state_next = lcbm_pkg::S_DONE;
                    pos_next = CW'(S);
                end
                else
                    pos_next = '0;
            end
            lcbm_pkg::S_DONE:
            begin
                // walk: pos_reg counts positions left above the current one
                if (pos_reg != '0 && freed_reg < target_reg)
                begin
                    pos_next = pos_reg - 1'b1;
                    cmd.slot = pos_slot[pos_next[SW-1:0]];
                    if (pos_valid[pos_next[SW-1:0]] && lock_reg[cmd.slot] == '0
                        && pres_reg[cmd.slot])
                    begin
                        cmd.op = lcbm_pkg::ORD_REMOVE;
                        pres_next[cmd.slot] = 1'b0;
                        total_next = total_reg - BW'(size_reg[cmd.slot]);
                        pcnt_next = pcnt_reg - 1'b1;
                        freed_next = freed_reg + BW'(size_reg[cmd.slot]);
                        mask_next[cmd.slot] = 1'b1;
                    end
                end
                else
                    state_next = lcbm_pkg::S_IDLE;
            end
            default: state_next = lcbm_pkg::S_IDLE;
        endcase
    end

    // Control and table state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lcbm_pkg::S_IDLE;
            budget_reg <= '0;
            alloc_reg <= '0;
            pres_reg <= '0;
            lock_reg <= '0;
            total_reg <= '0;
            acnt_reg <= '0;
            pcnt_reg <= '0;
            pos_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
                budget_reg <= cfg.data;
            alloc_reg <= alloc_next;
            pres_reg <= pres_next;
            lock_reg <= lock_next;
            total_reg <= total_next;
            acnt_reg <= acnt_next;
            pcnt_reg <= pcnt_next;
            pos_reg <= pos_next;
            if (state_reg == lcbm_pkg::S_DONE && state_next == lcbm_pkg::S_IDLE)
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
            req_reg <= req.payload;
        if (state_reg == lcbm_pkg::S_WALK && req_reg.action == lcbm_pkg::ACT_NEW
            && !alloc_reg[s])
            size_reg[s] <= csize;
        target_reg <= target_next;
        freed_reg <= freed_next;
        mask_reg <= mask_next;
        status_reg <= status_next;
        if (state_reg == lcbm_pkg::S_DONE && state_next == lcbm_pkg::S_IDLE)
        begin
            rsp_reg.status <= status_reg;
            rsp_reg.present <= pres_reg[s];
            rsp_reg.purged_bytes <= freed_reg;
            rsp_reg.evicted_mask <= mask_reg;
            rsp_reg.cache_bytes <= total_reg;
            rsp_reg.valid_count <= pcnt_reg;
            rsp_reg.object_count <= acnt_reg;
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == lcbm_pkg::S_IDLE))
        else $error("ready outside idle");
    a_present_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (pres_reg & ~alloc_reg) == '0)
        else $error("present slot not allocated");
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        pcnt_reg == CW'($countones(pres_reg)))
        else $error("present count mismatch");
    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(pos_valid) == $countones(pres_reg))
        else $error("order length mismatch");
endmodule

/* tb/sv/tb_lru_cache_budget_manager.sv */
`timescale 1ns / 100ps

module tb_lru_cache_budget_manager;

    localparam int MAX_CYCLES = 2000000;
    localparam int MAX_SHOWN = 10;
    localparam int SETTLE = 40;

    logic clk;
    logic rst_n;

    lcbm_req_if req_ch();
    lcbm_rsp_if rsp_ch();
    lcbm_cfg_if cfg_ch();

    lru_cache_budget_manager dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // Shadow copy of the slot table
    logic [lcbm_pkg::BYTES_W-1:0]   budget;
    logic                           sh_alloc [lcbm_pkg::SLOTS];
    logic                           sh_pres [lcbm_pkg::SLOTS];
    logic [lcbm_pkg::LOCK_BITS-1:0] sh_lock [lcbm_pkg::SLOTS];
    logic [lcbm_pkg::SIZE_W-1:0]    sh_size [lcbm_pkg::SLOTS];
    int                             recency [$];   // index 0 = most recent
    logic [lcbm_pkg::BYTES_W-1:0]   sh_total;
    int                             sh_alloc_cnt;
    int                             sh_pres_cnt;

    lcbm_pkg::rsp_t  pending_rsp [$];
    int    errors;
    int    shown;
    int    cycle_cnt;
    int    sent_cnt;
    int    rsp_cnt;
    int    purge_hits;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        cycle_cnt = 0;
        forever
        begin
            @(posedge clk);
            cycle_cnt++;
            if (cycle_cnt > MAX_CYCLES)
            begin
                $display("timeout after %0d cycles", cycle_cnt);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    function automatic void reset_shadow();
        budget = '0;
        for (int i = 0; i < lcbm_pkg::SLOTS; i++)
        begin
            sh_alloc[i] = 1'b0;
            sh_pres[i] = 1'b0;
            sh_lock[i] = '0;
            sh_size[i] = '0;
        end
        recency.delete();
        sh_total = '0;
        sh_alloc_cnt = 0;
        sh_pres_cnt = 0;
    endfunction

    // Walk from the least-recent end freeing unlocked present entries
    function automatic void lru_purge(input logic [lcbm_pkg::BYTES_W-1:0] amount,
                                      inout logic [lcbm_pkg::BYTES_W-1:0] freed,
                                      inout logic [lcbm_pkg::SLOTS-1:0] mask);
        int pos;
        int s;
        pos = recency.size();
        while (freed < amount && pos > 0)
        begin
            pos--;
            s = recency[pos];
            if (sh_lock[s] == 0 && sh_pres[s])
            begin
                sh_pres[s] = 1'b0;
                sh_total -= sh_size[s];
                sh_pres_cnt--;
                freed += sh_size[s];
                mask[s] = 1'b1;
                recency.delete(pos);
            end
        end
    endfunction

    function automatic void drop_from_order(input int s);
        for (int i = 0; i < recency.size(); i++)
            if (recency[i] == s)
            begin
                recency.delete(i);
                return;
            end
    endfunction

    function automatic lcbm_pkg::rsp_t predict_cache(input lcbm_pkg::req_t r);
        lcbm_pkg::rsp_t o;
        lcbm_pkg::status_t st;
        logic [lcbm_pkg::BYTES_W-1:0] freed;
        logic [lcbm_pkg::SLOTS-1:0] mask;
        logic [lcbm_pkg::SIZE_W-1:0] sz;
        logic [lcbm_pkg::BYTES_W-1:0] amt;
        int s;
        st = lcbm_pkg::ST_OK;
        freed = '0;
        mask = '0;
        s = r.slot;
        case (r.action)
            lcbm_pkg::ACT_PURGE:
            begin
                if (!r.own_pool)
                begin
                    amt = r.amount_unknown ? lcbm_pkg::UNKNOWN_PURGE_BYTES
                                           : r.purge_amount;
                    lru_purge(amt, freed, mask);
                end
            end
            lcbm_pkg::ACT_NEW:
            begin
                if (sh_alloc[s])
                    st = lcbm_pkg::ST_INVALID;
                else
                begin
                    sz = (r.entry_size > lcbm_pkg::MAX_ENTRY_BYTES)
                        ? lcbm_pkg::SIZE_W'(lcbm_pkg::MAX_ENTRY_BYTES) : r.entry_size;
                    sh_alloc[s] = 1'b1;
                    sh_pres[s] = 1'b1;
                    sh_lock[s] = '0;
                    sh_size[s] = sz;
                    sh_alloc_cnt++;
                    sh_pres_cnt++;
                    recency.push_front(s);
                    sh_total += sz;
                    if (budget != 0 && sh_total > budget)
                        lru_purge(sh_total - budget, freed, mask);
                end
            end
            lcbm_pkg::ACT_LOCK:
            begin
                if (!sh_alloc[s])
                    st = lcbm_pkg::ST_INVALID;
                else if (!sh_pres[s])
                    st = lcbm_pkg::ST_GONE;
                else if (sh_lock[s] != '1)
                    sh_lock[s]++;
            end
            lcbm_pkg::ACT_UNLOCK:
            begin
                if (!sh_alloc[s] || sh_lock[s] == 0)
                    st = lcbm_pkg::ST_INVALID;
                else
                begin
                    sh_lock[s]--;
                    if (sh_lock[s] == 0 && sh_pres[s])
                    begin
                        drop_from_order(s);
                        recency.push_front(s);
                    end
                end
            end
            lcbm_pkg::ACT_RELEASE:
            begin
                if (!sh_alloc[s])
                    st = lcbm_pkg::ST_INVALID;
                else
                begin
                    if (sh_pres[s])
                    begin
                        drop_from_order(s);
                        sh_total -= sh_size[s];
                        sh_pres_cnt--;
                        sh_pres[s] = 1'b0;
                    end
                    sh_alloc[s] = 1'b0;
                    sh_lock[s] = '0;
                    sh_alloc_cnt--;
                end
            end
            lcbm_pkg::ACT_QUERY: ;
            default: st = lcbm_pkg::ST_INVALID;
        endcase
        o.status = st;
        o.present = sh_pres[s];
        o.purged_bytes = freed;
        o.evicted_mask = mask;
        o.cache_bytes = sh_total;
        o.valid_count = lcbm_pkg::CNT_W'(sh_pres_cnt);
        o.object_count = lcbm_pkg::CNT_W'(sh_alloc_cnt);
        return o;
    endfunction

    // Response checker
    initial
    begin
        errors = 0;
        shown = 0;
        rsp_cnt = 0;
        purge_hits = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_cnt++;
                if (pending_rsp.size() == 0)
                begin
                    errors++;
                    if (shown < MAX_SHOWN)
                    begin
                        shown++;
                        $display("unexpected response %p", rsp_ch.payload);
                    end
                end
                else
                begin
                    lcbm_pkg::rsp_t e;
                    e = pending_rsp.pop_front();
                    if (e.evicted_mask != 0)
                        purge_hits++;
                    if (rsp_ch.payload !== e)
                    begin
                        errors++;
                        if (shown < MAX_SHOWN)
                        begin
                            shown++;
                            $display("mismatch rsp %0d: exp %p got %p",
                                     rsp_cnt, e, rsp_ch.payload);
                        end
                    end
                end
            end
        end
    end

    // Receiver stalls
    initial
    begin
        int gap;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            gap = ($urandom_range(0, 19) == 0) ? $urandom_range(5, 30)
                                               : $urandom_range(0, 2);
            if ($urandom_range(0, 3) == 0)
                gap = 0;
            if (gap == 0)
                rsp_ch.ready = 1'b1;
            else
            begin
                rsp_ch.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
                rsp_ch.ready = 1'b1;
            end
        end
    end

    task automatic send_request(input lcbm_pkg::req_t r, input logic chk_typed,
                                input lcbm_pkg::rsp_t typed);
        lcbm_pkg::rsp_t e;
        int gap;
        gap = ($urandom_range(0, 24) == 0) ? $urandom_range(5, 30)
                                           : $urandom_range(0, 2);
        if ($urandom_range(0, 2) == 0)
            gap = 0;
        if (gap > 0)
        begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.payload = r;
        req_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        e = predict_cache(r);
        if (chk_typed && e !== typed)
        begin
            errors++;
            if (shown < MAX_SHOWN)
            begin
                shown++;
                $display("table row mismatch: typed %p predicted %p", typed, e);
            end
        end
        pending_rsp.push_back(e);
        sent_cnt++;
        @(negedge clk);
        req_ch.valid = 1'b0;
    endtask

    task automatic drain_responses();
        while (pending_rsp.size() != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_budget(input logic [lcbm_pkg::BYTES_W-1:0] v);
        drain_responses();
        cfg_ch.data = v;
        cfg_ch.valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        budget = v;
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic lcbm_pkg::req_t mk_req(input lcbm_pkg::action_t a, input int s,
                                              input int sz, input int amt,
                                              input bit unk, input bit own);
        lcbm_pkg::req_t r;
        r.action = a;
        r.slot = lcbm_pkg::SLOT_W'(s);
        r.entry_size = lcbm_pkg::SIZE_W'(sz);
        r.purge_amount = lcbm_pkg::BYTES_W'(amt);
        r.amount_unknown = unk;
        r.own_pool = own;
        return r;
    endfunction

    function automatic lcbm_pkg::rsp_t mk_rsp(input lcbm_pkg::status_t st, input bit p,
                                              input int cb, input int vc, input int oc);
        lcbm_pkg::rsp_t o;
        o.status = st;
        o.present = p;
        o.purged_bytes = '0;
        o.evicted_mask = '0;
        o.cache_bytes = lcbm_pkg::BYTES_W'(cb);
        o.valid_count = lcbm_pkg::CNT_W'(vc);
        o.object_count = lcbm_pkg::CNT_W'(oc);
        return o;
    endfunction

    // Random request, mostly well-formed over a live table
    function automatic lcbm_pkg::req_t rand_req();
        lcbm_pkg::req_t r;
        int k;
        r = $bits(lcbm_pkg::req_t)'({$urandom, $urandom});
        k = $urandom_range(0, 99);
        if (k < 30)
            r.action = lcbm_pkg::ACT_NEW;
        else if (k < 50)
            r.action = lcbm_pkg::ACT_LOCK;
        else if (k < 68)
            r.action = lcbm_pkg::ACT_UNLOCK;
        else if (k < 80)
            r.action = lcbm_pkg::ACT_RELEASE;
        else if (k < 90)
            r.action = lcbm_pkg::ACT_PURGE;
        else if (k < 97)
            r.action = lcbm_pkg::ACT_QUERY;
        else
            r.action = lcbm_pkg::action_t'($urandom_range(6, 7));
        if ($urandom_range(0, 9) != 0)
            r.entry_size = lcbm_pkg::SIZE_W'($urandom_range(0, 1200));
        if ($urandom_range(0, 3) != 0)
            r.purge_amount = lcbm_pkg::BYTES_W'($urandom_range(0, 5000));
        r.amount_unknown = ($urandom_range(0, 7) == 0);
        r.own_pool = ($urandom_range(0, 7) == 0);
        return r;
    endfunction

    typedef struct {
        lcbm_pkg::req_t r;
        bit             chk;
        lcbm_pkg::rsp_t o;
    } stim_row_t;

    initial
    begin
        stim_row_t rows [$];
        logic [lcbm_pkg::BYTES_W-1:0] budgets [6];
        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        sent_cnt = 0;
        reset_shadow();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table, no budget
        rows.push_back('{mk_req(lcbm_pkg::ACT_QUERY, 0, 0, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_OK, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_LOCK, 3, 0, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_UNLOCK, 3, 0, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_RELEASE, 3, 0, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::action_t'(3'd6), 0, 0, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::action_t'(3'd7), 15, 8191, 0, 1, 1), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 0, 0, 0, 0)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_NEW, 0, 8191, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_OK, 1, 4096, 1, 1)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_NEW, 0, 10, 0, 0, 0), 1,
                         mk_rsp(lcbm_pkg::ST_INVALID, 1, 4096, 1, 1)});
        rows.push_back('{mk_req(lcbm_pkg::ACT_NEW, 15, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_NEW, 7, 4096, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_LOCK, 7, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_PURGE, 0, 0, 24'hFFFFFF, 0, 1), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_PURGE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_PURGE, 0, 0, 0, 1, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_LOCK, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_UNLOCK, 7, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_UNLOCK, 7, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_RELEASE, 7, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_RELEASE, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk_req(lcbm_pkg::ACT_RELEASE, 15, 0, 0, 0, 0), 0, '0});
        foreach (rows[i])
            send_request(rows[i].r, rows[i].chk, rows[i].o);

        // Lock saturation and budget self-purge
        write_budget(24'd3000);
        send_request(mk_req(lcbm_pkg::ACT_NEW, 2, 100, 0, 0, 0), 0, '0);
        repeat (260) send_request(mk_req(lcbm_pkg::ACT_LOCK, 2, 0, 0, 0, 0), 0, '0);
        send_request(mk_req(lcbm_pkg::ACT_UNLOCK, 2, 0, 0, 0, 0), 0, '0);
        send_request(mk_req(lcbm_pkg::ACT_NEW, 5, 4096, 0, 0, 0), 0, '0);
        send_request(mk_req(lcbm_pkg::ACT_RELEASE, 2, 0, 0, 0, 0), 0, '0);
        send_request(mk_req(lcbm_pkg::ACT_RELEASE, 5, 0, 0, 0, 0), 0, '0);

        // Random phases over several budgets
        budgets = '{24'd0, 24'hFFFFFF, 24'd1, 24'd4000, 24'd9000, 24'd2500};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_budget(budgets[ph]);
            for (int n = 0; n < 240; n++)
            begin
                send_request(rand_req(), 0, '0);
                if (n == 120)
                    drain_responses();
            end
        end

        drain_responses();
        $display("sent %0d requests, %0d responses, %0d with evictions",
                 sent_cnt, rsp_cnt, purge_hits);
        $display("covered all actions, lock saturation, budgets 0 to max");
        if (errors == 0 && pending_rsp.size() == 0)
            $display("Test completed successfully");
        else
        begin
            $display("%0d errors, %0d left pending", errors, pending_rsp.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
